// File: design/jlsr_pkg.sv
`timescale 1ns / 1ps

package jlsr_pkg;

  // Fixed-point format of speed, acceleration and jerk.
  localparam int FRAC_BITS = 16;
  // Fraction bits of the time step.
  localparam int DT_BITS   = 24;

  localparam int VAL_W   = 31;  // unsigned register and speed width
  localparam int ACC_W   = 32;  // signed acceleration width
  localparam int DT_W    = 24;  // step time width
  localparam int OPND_W  = 33;  // signed operand width of the shared multiplier
  localparam int PROD_W  = 2 * OPND_W;
  localparam int RAD_W   = 64;  // square root radicand width
  localparam int ROOT_W  = 32;

  // Error band in which the ramp snaps to the goal: 0.01 rounded to the grid.
  localparam logic [VAL_W-1:0] DEADBAND =
    VAL_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  // Status of the square root unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// File: design/jerk_limited_speed_ramp_core.sv
`timescale 1ns / 1ps

// Jerk-limited S-curve speed ramp in fixed point. Each transfer on the input
// channel is either a tick, carrying a goal speed and a time step, or a clear,
// and produces exactly one result with the new speed and acceleration. A tick
// outside the deadband goes through the braking curve square root, which
// produces one bit per cycle, and three products share one registered
// multiplier. A clear or a tick inside the deadband goes from the error check
// straight to the final step. The input stalls until the sequencer is back in
// idle, which happens as the result is loaded, so a new item is taken only once
// the last one is finished, and a stalled earlier result can hold up the final
// step. A finished result waits in the output register and the next item can
// be taken meanwhile. The limits and jerks are written through the cfg port;
// the user must write them only while the ramp is idle; no check enforces it.
module jerk_limited_speed_ramp_core #(
  parameter int FRAC_BITS = jlsr_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [jlsr_pkg::ACC_W-1:0]   in_goal_speed,
  input  logic [jlsr_pkg::DT_W-1:0]           in_step_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [jlsr_pkg::VAL_W-1:0]          out_speed_out,
  output logic signed [jlsr_pkg::ACC_W-1:0]   out_accel_out,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [jlsr_pkg::VAL_W-1:0]          cfg_data
);

  localparam int VW = jlsr_pkg::VAL_W;
  localparam int AW = jlsr_pkg::ACC_W;
  localparam int OW = jlsr_pkg::OPND_W;
  localparam int DB = jlsr_pkg::DT_BITS;

  // Error band in which the ramp snaps to the goal: 0.01 rounded to the grid.
  localparam logic [VW-1:0] DEADBAND =
    VW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd1;
  localparam logic [2:0] REG_DECEL_LIMIT = 3'd2;
  localparam logic [2:0] REG_RISE_JERK   = 3'd3;
  localparam logic [2:0] REG_FALL_JERK   = 3'd4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_JERK  = 4'd4;
  localparam logic [3:0] S_SLEW  = 4'd5;
  localparam logic [3:0] S_MULV  = 4'd6;
  localparam logic [3:0] S_INTEG = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [VW-1:0] speed_limit_r, accel_limit_r, decel_limit_r, rise_jerk_r, fall_jerk_r;

  logic [3:0]             state_r, state_nxt;
  logic [VW-1:0]          speed_now_r, speed_now_nxt;
  logic signed [AW-1:0]   accel_now_r, accel_now_nxt;
  logic [VW-1:0]          goal_r, goal_nxt;
  logic [jlsr_pkg::DT_W-1:0] dt_r, dt_nxt;
  logic                   kind_r, kind_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [AW-1:0]   desired_r, desired_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VW-1:0]          out_speed_r, out_speed_nxt;
  logic signed [AW-1:0]   out_accel_r, out_accel_nxt;

  logic signed [OW-1:0]              mul_a, mul_b;
  logic signed [jlsr_pkg::PROD_W-1:0] prod_r;
  logic                              sqrt_start;
  jlsr_pkg::sqrt_stat_t              sqrt_stat;
  logic [jlsr_pkg::ROOT_W-1:0]       sqrt_root;

  logic                   in_xfer;
  logic signed [OW-1:0]   err;
  logic [VW-1:0]          aerr;
  logic [jlsr_pkg::ROOT_W-1:0] root_lim;
  logic                   accel_up;
  logic [VW-1:0]          jerk_sel;
  logic [VW-1:0]          maxchg;
  logic signed [OW-1:0]   diff;
  logic [OW-1:0]          adiff;
  logic signed [OW:0]     slewed;
  logic signed [OW:0]     delta;
  logic signed [OW:0]     ns;

  jlsr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  jlsr_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value ({prod_r[jlsr_pkg::RAD_W-2:0], 1'b0}),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Datapath values, each meaningful only in the state that uses it.
  assign err  = $signed({2'b00, goal_r}) - $signed({2'b00, speed_now_r});
  assign aerr = err[OW-1] ? VW'(-err) : err[VW-1:0];

  assign accel_up = desired_r > accel_now_r;
  assign jerk_sel = (accel_up && !accel_now_r[AW-1]) ? rise_jerk_r : fall_jerk_r;

  assign maxchg = prod_r[DB+VW-1:DB];
  assign diff   = OW'(desired_r) - OW'(accel_now_r);
  assign adiff  = diff[OW-1] ? OW'(-diff) : OW'(diff);
  assign slewed = diff[OW-1] ? ((OW+1)'(accel_now_r) - $signed({3'b000, maxchg}))
                             : ((OW+1)'(accel_now_r) + $signed({3'b000, maxchg}));

  // Floor of the signed product over the step time scale.
  assign delta = prod_r[DB+OW:DB];
  assign ns    = $signed({3'b000, speed_now_r}) + delta;

  always_comb begin
    state_nxt     = state_r;
    speed_now_nxt = speed_now_r;
    accel_now_nxt = accel_now_r;
    goal_nxt      = goal_r;
    dt_nxt        = dt_r;
    kind_nxt      = kind_r;
    neg_nxt       = neg_r;
    desired_nxt   = desired_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_speed_nxt = out_speed_r;
    out_accel_nxt = out_accel_r;
    mul_a         = '0;
    mul_b         = '0;
    sqrt_start    = 1'b0;
    root_lim      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_kind;
          dt_nxt   = in_step_time;
          if (in_goal_speed[AW-1]) begin
            goal_nxt = '0;
          end else if (in_goal_speed[VW-1:0] > speed_limit_r) begin
            goal_nxt = speed_limit_r;
          end else begin
            goal_nxt = in_goal_speed[VW-1:0];
          end
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        neg_nxt = err[OW-1];
        mul_a   = $signed({2'b00, fall_jerk_r});
        mul_b   = $signed({2'b00, aerr});
        if (kind_r) begin
          speed_now_nxt = '0;
          accel_now_nxt = '0;
          state_nxt     = S_DONE;
        end else if (aerr < DEADBAND) begin
          speed_now_nxt = goal_r;
          accel_now_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        sqrt_start = 1'b1;
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_stat.done) begin
          if (neg_r) begin
            root_lim    = (sqrt_root > {1'b0, decel_limit_r}) ? {1'b0, decel_limit_r}
                                                               : sqrt_root;
            desired_nxt = -$signed(root_lim);
          end else begin
            root_lim    = (sqrt_root > {1'b0, accel_limit_r}) ? {1'b0, accel_limit_r}
                                                               : sqrt_root;
            desired_nxt = $signed(root_lim);
          end
          state_nxt = S_JERK;
        end
      end
      S_JERK: begin
        mul_a     = $signed({2'b00, jerk_sel});
        mul_b     = $signed({9'd0, dt_r});
        state_nxt = S_SLEW;
      end
      S_SLEW: begin
        if (adiff > OW'(maxchg)) begin
          if (slewed < -$signed({3'b000, decel_limit_r})) begin
            accel_now_nxt = -$signed({1'b0, decel_limit_r});
          end else if (slewed > $signed({3'b000, accel_limit_r})) begin
            accel_now_nxt = $signed({1'b0, accel_limit_r});
          end else begin
            accel_now_nxt = slewed[AW-1:0];
          end
        end else begin
          // The desired value already lies inside both limits.
          accel_now_nxt = desired_r;
        end
        state_nxt = S_MULV;
      end
      S_MULV: begin
        mul_a     = OW'(accel_now_r);
        mul_b     = $signed({9'd0, dt_r});
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        if (ns > $signed({3'b000, speed_limit_r})) begin
          speed_now_nxt = speed_limit_r;
          if (accel_now_r > 0) begin
            accel_now_nxt = '0;
          end
        end else if (ns[OW]) begin
          speed_now_nxt = '0;
          if (accel_now_r[AW-1]) begin
            accel_now_nxt = '0;
          end
        end else begin
          speed_now_nxt = ns[VW-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = speed_now_r;
          out_accel_nxt = accel_now_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      speed_now_r   <= '0;
      accel_now_r   <= '0;
      speed_limit_r <= '0;
      accel_limit_r <= '0;
      decel_limit_r <= '0;
      rise_jerk_r   <= '0;
      fall_jerk_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      speed_now_r <= speed_now_nxt;
      accel_now_r <= accel_now_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED_LIMIT: speed_limit_r <= cfg_data;
          REG_ACCEL_LIMIT: accel_limit_r <= cfg_data;
          REG_DECEL_LIMIT: decel_limit_r <= cfg_data;
          REG_RISE_JERK:   rise_jerk_r   <= cfg_data;
          REG_FALL_JERK:   fall_jerk_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    goal_r      <= goal_nxt;
    dt_r        <= dt_nxt;
    kind_r      <= kind_nxt;
    neg_r       <= neg_nxt;
    desired_r   <= desired_nxt;
    out_speed_r <= out_speed_nxt;
    out_accel_r <= out_accel_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_speed_out = out_speed_r;
  assign out_accel_out = out_accel_r;

`ifndef SYNTHESIS
  // A new result is only ever loaded from the final state of an item.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared outside the final state");

  // While the sequencer waits on the root, the root unit is working or finished.
  a_sqrt_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> sqrt_stat.busy || sqrt_stat.done)
    else $error("waiting on a square root that is not running");

  // An accepted item always starts work in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_ERR)
    else $error("accepted item did not start");

  // The root unit finishes only while the sequencer waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_stat.done |-> state_r == S_SQRT)
    else $error("square root finished unexpectedly");
`endif

endmodule

// File: design/jlsr_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module jlsr_mul (
  input  logic                                  clk,
  input  logic signed [jlsr_pkg::OPND_W-1:0]    a,
  input  logic signed [jlsr_pkg::OPND_W-1:0]    b,
  output logic signed [jlsr_pkg::PROD_W-1:0]    p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// File: design/jlsr_isqrt.sv
`timescale 1ns / 1ps

// Integer square root rounded down, one result bit per cycle.
module jlsr_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jlsr_pkg::RAD_W-1:0]    value,
  output jlsr_pkg::sqrt_stat_t          stat,
  output logic [jlsr_pkg::ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(jlsr_pkg::ROOT_W);

  logic [jlsr_pkg::RAD_W-1:0] rem_r, rem_nxt;
  logic [jlsr_pkg::RAD_W-1:0] res_r, res_nxt;
  logic [jlsr_pkg::RAD_W-1:0] bit_r, bit_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [jlsr_pkg::RAD_W-1:0] trial;
  logic [jlsr_pkg::RAD_W:0]   diff;

  assign trial = res_r + bit_r;
  assign diff  = {1'b0, rem_r} - {1'b0, trial};

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = value;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(jlsr_pkg::RAD_W-2){1'b0}}};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The borrow of the subtraction decides whether this bit is set.
      if (!diff[jlsr_pkg::RAD_W]) begin
        rem_nxt = diff[jlsr_pkg::RAD_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(jlsr_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[jlsr_pkg::ROOT_W-1:0];

endmodule

// File: tb/jerk_limited_speed_ramp_core_tb.sv
`timescale 1ns / 1ps

module jerk_limited_speed_ramp_core_tb;

  localparam int FRAC_BITS = jlsr_pkg::FRAC_BITS;
  localparam int DT_BITS   = jlsr_pkg::DT_BITS;
  localparam int VAL_W     = jlsr_pkg::VAL_W;
  localparam int ACC_W     = jlsr_pkg::ACC_W;
  localparam int DT_W      = jlsr_pkg::DT_W;
  localparam logic [VAL_W-1:0] DEADBAND = jlsr_pkg::DEADBAND;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd0;
  localparam logic [2:0] REG_ACCEL_LIMIT  = 3'd1;
  localparam logic [2:0] REG_DECEL_LIMIT  = 3'd2;
  localparam logic [2:0] REG_RISE_JERK    = 3'd3;
  localparam logic [2:0] REG_FALL_JERK    = 3'd4;
  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REG_INDEX_MAX    = 3'd7;

  localparam int     IDLE_LIMIT      = 5000;
  localparam int     ITEMS_PER_PHASE = 325;
  localparam int     MAX_PRINTED     = 30;
  localparam longint ONE             = longint'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [DT_W-1:0]  DT_MAX  = '1;

  typedef struct packed {
    logic [VAL_W-1:0]        speed;
    logic signed [ACC_W-1:0] accel;
  } ramp_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_kind = KIND_TICK;
  logic signed [ACC_W-1:0] in_goal_speed = '0;
  logic [DT_W-1:0]         in_step_time = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [VAL_W-1:0]        out_speed_out;
  logic signed [ACC_W-1:0] out_accel_out;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = REG_SPEED_LIMIT;
  logic [VAL_W-1:0]        cfg_data = '0;

  // Predicted register contents and ramp state.
  longint lim_speed = 0, lim_accel = 0, lim_decel = 0, jerk_rise = 0, jerk_fall = 0;
  longint ramp_speed = 0, ramp_accel = 0, ramp_goal = 0;

  ramp_result_t pending_ramp_q[$];

  int     err_count = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     hold_left = 0;
  longint hold_goal = 0;
  int     stall_run = 0;
  int     stall_pct = 0;
  int     stall_epoch = 0;

  jerk_limited_speed_ramp_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_goal_speed (in_goal_speed),
    .in_step_time  (in_step_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_speed_out (out_speed_out),
    .out_accel_out (out_accel_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Floor square root, settled one result bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic ramp_result_t ramp_advance(input logic kind,
                                                input logic [ACC_W-1:0] goal_raw,
                                                input logic [DT_W-1:0] dt_raw);
    longint dt, err, aerr, desired, diff, jerk, maxchg, adiff, next_speed;
    ramp_result_t res;
    dt = longint'(dt_raw);
    if (kind == KIND_CLEAR) begin
      ramp_speed = 0;
      ramp_accel = 0;
      ramp_goal  = 0;
    end else begin
      ramp_goal = longint'($signed(goal_raw));
      if (ramp_goal < 0) ramp_goal = 0;
      if (ramp_goal > lim_speed) ramp_goal = lim_speed;
      err  = ramp_goal - ramp_speed;
      aerr = (err < 0) ? -err : err;
      if (aerr < longint'(DEADBAND)) begin
        ramp_accel = 0;
        ramp_speed = ramp_goal;
      end else begin
        desired = longint'(floor_root(longint'(2) * jerk_fall * aerr));
        if (err < 0) desired = -desired;
        if (desired > 0) begin
          if (desired > lim_accel) desired = lim_accel;
        end else if (desired < -lim_decel) begin
          desired = -lim_decel;
        end
        // The rising jerk applies only while acceleration grows from zero or above.
        diff   = desired - ramp_accel;
        jerk   = (desired > ramp_accel && ramp_accel >= 0) ? jerk_rise : jerk_fall;
        maxchg = (jerk * dt) >>> DT_BITS;
        adiff  = (diff < 0) ? -diff : diff;
        if (adiff > maxchg) ramp_accel += (diff < 0) ? -maxchg : maxchg;
        else ramp_accel = desired;
        if (ramp_accel < -lim_decel) ramp_accel = -lim_decel;
        if (ramp_accel > lim_accel) ramp_accel = lim_accel;
        next_speed = ramp_speed + ((ramp_accel * dt) >>> DT_BITS);
        if (next_speed > lim_speed) begin
          next_speed = lim_speed;
          if (ramp_accel > 0) ramp_accel = 0;
        end else if (next_speed < 0) begin
          next_speed = 0;
          if (ramp_accel < 0) ramp_accel = 0;
        end
        ramp_speed = next_speed;
      end
    end
    res.speed = ramp_speed[VAL_W-1:0];
    res.accel = ramp_accel[ACC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Valid stays high between items of one burst; it drops only before a gap.
  task automatic send_item(input logic kind, input logic [ACC_W-1:0] goal,
                           input logic [DT_W-1:0] dt);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = 150;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 30);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_goal_speed <= goal;
    in_step_time  <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_ramp_q.push_back(ramp_advance(kind, goal, dt));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_ramp_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [VAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_limits(input logic [VAL_W-1:0] sl, input logic [VAL_W-1:0] al,
                             input logic [VAL_W-1:0] dl, input logic [VAL_W-1:0] rj,
                             input logic [VAL_W-1:0] fj);
    cfg_put(REG_SPEED_LIMIT, sl);
    cfg_put(REG_ACCEL_LIMIT, al);
    cfg_put(REG_DECEL_LIMIT, dl);
    cfg_put(REG_RISE_JERK, rj);
    cfg_put(REG_FALL_JERK, fj);
    // A write to an unmapped index must leave every limit alone.
    cfg_put(3'($urandom_range(int'(REG_FIRST_UNUSED), int'(REG_INDEX_MAX))),
            VAL_W'($urandom));
    cfg_we <= 1'b0;
    lim_speed = longint'(sl);
    lim_accel = longint'(al);
    lim_decel = longint'(dl);
    jerk_rise = longint'(rj);
    jerk_fall = longint'(fj);
  endtask

  task automatic test_after_reset();
    // All limits are zero, so any goal clamps to zero.
    send_item(KIND_TICK, ACC_W'(VAL_MAX), DT_MAX);
    send_item(KIND_CLEAR, ACC_W'($urandom), DT_W'($urandom));
    settle();
  endtask

  task automatic test_ramp_shape();
    load_limits(VAL_W'(100 * ONE), VAL_W'(20 * ONE), VAL_W'(30 * ONE),
                VAL_W'(50 * ONE), VAL_W'(80 * ONE));
    send_item(KIND_TICK, 32'h8000_0000, '0);
    // A zero time step leaves acceleration and speed where they are.
    send_item(KIND_TICK, ACC_W'(50 * ONE), '0);
    send_item(KIND_TICK, 32'h7FFF_FFFF, DT_MAX);
    repeat (6) send_item(KIND_TICK, ACC_W'(60 * ONE), DT_W'(24'h04_0000));
    send_item(KIND_TICK, ACC_W'(ramp_speed + longint'(DEADBAND) - 1), DT_W'(24'h04_0000));
    send_item(KIND_TICK, ACC_W'(ramp_speed + longint'(DEADBAND)), DT_W'(24'h04_0000));
    repeat (3) send_item(KIND_TICK, '0, DT_MAX);
    send_item(KIND_CLEAR, ACC_W'($urandom), DT_W'($urandom));
    settle();
  endtask

  task automatic test_speed_walls();
    load_limits(VAL_W'(10 * ONE), VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    send_item(KIND_TICK, ACC_W'(10 * ONE), DT_MAX);
    send_item(KIND_TICK, ACC_W'(10 * ONE), DT_MAX);
    send_item(KIND_TICK, '0, DT_MAX);
    settle();
  endtask

  task automatic test_zero_braking_curve();
    load_limits(VAL_W'(100 * ONE), VAL_W'(20 * ONE), VAL_W'(30 * ONE),
                VAL_W'(50 * ONE), '0);
    send_item(KIND_TICK, ACC_W'(50 * ONE), DT_W'(24'h10_0000));
    send_item(KIND_TICK, ACC_W'(50 * ONE), DT_W'(24'h10_0000));
    settle();
  endtask

  task automatic test_limit_lowered();
    load_limits(VAL_W'(100 * ONE), VAL_W'(40 * ONE), VAL_W'(40 * ONE),
                VAL_W'(200 * ONE), VAL_W'(200 * ONE));
    repeat (3) send_item(KIND_TICK, ACC_W'(80 * ONE), DT_W'(24'h40_0000));
    settle();
    // The held speed now sits exactly at the new limit, with acceleration still positive.
    load_limits(VAL_W'(30 * ONE), VAL_W'(40 * ONE), VAL_W'(40 * ONE),
                VAL_W'(200 * ONE), VAL_W'(200 * ONE));
    repeat (2) send_item(KIND_TICK, ACC_W'(80 * ONE), DT_W'(24'h40_0000));
    settle();
  endtask

  // Mostly a goal held over a run of ticks so the ramp gets to settle,
  // mixed with full-range goals and the odd clear.
  task automatic random_phase(input logic [VAL_W-1:0] sl, input logic [VAL_W-1:0] al,
                              input logic [VAL_W-1:0] dl, input logic [VAL_W-1:0] rj,
                              input logic [VAL_W-1:0] fj);
    logic             kind;
    logic [ACC_W-1:0] goal;
    logic [DT_W-1:0]  dt;
    int               pick;
    settle();
    load_limits(sl, al, dl, rj, fj);
    hold_left = 0;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      kind = KIND_TICK;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kind = KIND_CLEAR;
        goal = ACC_W'($urandom);
      end else if (pick < 10) begin
        goal = ACC_W'($urandom);
      end else begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(3, 40);
          if ($urandom_range(0, 9) == 0)
            hold_goal = ramp_speed + longint'($urandom_range(0, 2 * int'(DEADBAND)))
                        - longint'(DEADBAND);
          else
            hold_goal = longint'($urandom_range(0, int'(lim_speed)));
        end
        hold_left--;
        goal = ACC_W'(hold_goal);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) dt = DT_W'($urandom_range(0, 24'h02_0000));
      else if (pick < 8) dt = DT_W'($urandom);
      else dt = DT_W'($urandom_range(24'h04_0000, 24'h40_0000));
      send_item(kind, goal, dt);
    end
  endtask

  task automatic test_random_sweeps();
    random_phase(VAL_W'($urandom_range(1, 500) * ONE), VAL_W'($urandom_range(1, 200) * ONE),
                 VAL_W'($urandom_range(1, 200) * ONE), VAL_W'($urandom_range(1, 1000) * ONE),
                 VAL_W'($urandom_range(1, 1000) * ONE));
    random_phase(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    random_phase(VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                 VAL_W'($urandom), VAL_W'($urandom));
    random_phase(VAL_W'($urandom), '0, '0, '0, '0);
    random_phase(VAL_MAX, VAL_W'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 3)),
                 VAL_W'($urandom_range(1, 50) * ONE), VAL_W'($urandom_range(1, 50) * ONE));
    random_phase(VAL_W'($urandom_range(1, 300) * ONE), VAL_MAX,
                 VAL_W'($urandom_range(1, 100) * ONE), VAL_W'($urandom_range(1, 400) * ONE),
                 VAL_MAX);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_ramp_shape();
    test_speed_walls();
    test_zero_braking_curve();
    test_limit_lowered();
    test_random_sweeps();
    settle();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("[jerk_limited_speed_ramp_core] OK");
    end else begin
      $display("[jerk_limited_speed_ramp_core] ERROR");
    end
    $finish;
  end

  // Result side: the stall level changes in runs, and the odds drift over time.
  always @(posedge clk) begin
    if (stall_epoch == 0) begin
      stall_epoch = $urandom_range(100, 600);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_epoch--;
    if (stall_run == 0) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run = $urandom_range(1, 8);
    end
    stall_run--;
  end

  always @(posedge clk) begin : check_results
    ramp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ramp_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: speed=%h accel=%h",
                                  out_speed_out, out_accel_out));
      end else begin
        want = pending_ramp_q.pop_front();
        if (out_speed_out !== want.speed)
          report_mismatch($sformatf("speed_out got %h want %h", out_speed_out, want.speed));
        if (out_accel_out !== want.accel)
          report_mismatch($sformatf("accel_out got %h want %h", out_accel_out, want.accel));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[jerk_limited_speed_ramp_core] ERROR");
      $finish;
    end
  end

endmodule

// File: jerk_limited_speed_ramp_core.f
design/jlsr_pkg.sv
design/jlsr_mul.sv
design/jlsr_isqrt.sv
design/jerk_limited_speed_ramp_core.sv
tb/jerk_limited_speed_ramp_core_tb.sv
